>>> sv/i2ew_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2ew_pkg
// Shared types, word codes and helpers for the integer to word token unit.
// ----------------------------------------------------------------------------
package i2ew_pkg;

    localparam int VALUE_W    = 31;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CONV_STEPS = VALUE_W;

    typedef logic [4:0] t_word;
    typedef logic [3:0] t_digit;

    localparam t_word W_ZERO     = 5'd0;
    localparam t_word W_TEN      = 5'd10;
    localparam t_word W_TENS_OFS = 5'd18;
    localparam t_word W_HUNDRED  = 5'd28;
    localparam t_word W_THOUSAND = 5'd29;
    localparam t_word W_MILLION  = 5'd30;
    localparam t_word W_BILLION  = 5'd31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        P_HDIGIT,
        P_HWORD,
        P_TENS,
        P_ONES,
        P_SCALE
    } t_phase;

    // true when every packed digit is a decimal digit
    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

>>> sv/i2ew_bcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2ew_bcd
// Bit-serial binary to decimal converter: shift-and-add-three, one input bit
// per cycle, ten digits corrected in parallel.
// ----------------------------------------------------------------------------
module i2ew_bcd (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [i2ew_pkg::VALUE_W-1:0] i_value,
    output logic      [i2ew_pkg::BCD_W-1:0]   o_bcd,
    output logic                              o_done
);

    logic [i2ew_pkg::VALUE_W-1:0] r_shift;
    logic [i2ew_pkg::BCD_W-1:0]   r_bcd;
    logic [i2ew_pkg::BCD_W-1:0]   n_adj;
    logic [4:0]                   r_cnt;
    logic                         r_busy;
    logic                         r_done;

    always_comb begin
        for (int i = 0; i < i2ew_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(i2ew_pkg::CONV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_bcd   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[i2ew_pkg::VALUE_W-2:0], 1'b0};
            r_bcd   <= {n_adj[i2ew_pkg::BCD_W-2:0], r_shift[i2ew_pkg::VALUE_W-1]};
        end
    end

    assign o_bcd  = r_bcd;
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> sv/integer_to_english_word_tokens_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_unit
// Names a 31-bit unsigned integer as a sequence of English word tokens.
// ----------------------------------------------------------------------------
// One value is taken when o_ready is high (the unit is idle). The value is
// converted to ten decimal digits bit-serially, then a sequencer walks the
// billions, millions, thousands and units groups, five steps per group, 20
// steps in all, one step per cycle while the output register can take a
// token. Tokens leave through a one-token holding stage, so the final token
// carries o_last; the value zero gives the single token Zero. The next value
// is accepted once the last token sits in the output register.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [30:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_word,
    output logic             o_last
);

    i2ew_pkg::t_state r_state;
    i2ew_pkg::t_state n_state;
    i2ew_pkg::t_phase r_ph;
    i2ew_pkg::t_phase n_ph;

    logic [1:0]                 r_grp;
    logic [1:0]                 n_grp;
    logic [i2ew_pkg::BCD_W-1:0] bcd;
    logic                       bcd_done;
    logic                       start;

    i2ew_pkg::t_digit dh;
    i2ew_pkg::t_digit dt;
    i2ew_pkg::t_digit d_o;
    i2ew_pkg::t_word  scale;
    logic             has_scale;
    logic             grp_nz;

    logic             gen_valid;
    i2ew_pkg::t_word  gen_word;
    logic             out_free;
    logic             step_ok;
    logic             emit_end;

    logic             r_pend_valid;
    logic             n_pend_valid;
    i2ew_pkg::t_word  r_pend_word;
    i2ew_pkg::t_word  n_pend_word;
    logic             r_out_valid;
    logic             n_out_valid;
    i2ew_pkg::t_word  r_out_word;
    i2ew_pkg::t_word  n_out_word;
    logic             r_out_last;
    logic             n_out_last;

    i2ew_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (i_value),
        .o_bcd   (bcd),
        .o_done  (bcd_done)
    );

    // digits and scale word of the current group
    always_comb begin
        case (r_grp)
            2'd3: begin
                dh        = '0;
                dt        = '0;
                d_o       = bcd[39:36];
                scale     = i2ew_pkg::W_BILLION;
                has_scale = 1'b1;
            end
            2'd2: begin
                dh        = bcd[35:32];
                dt        = bcd[31:28];
                d_o       = bcd[27:24];
                scale     = i2ew_pkg::W_MILLION;
                has_scale = 1'b1;
            end
            2'd1: begin
                dh        = bcd[23:20];
                dt        = bcd[19:16];
                d_o       = bcd[15:12];
                scale     = i2ew_pkg::W_THOUSAND;
                has_scale = 1'b1;
            end
            default: begin
                dh        = bcd[11:8];
                dt        = bcd[7:4];
                d_o       = bcd[3:0];
                scale     = i2ew_pkg::W_ZERO;
                has_scale = 1'b0;
            end
        endcase
        grp_nz = (dh != '0) || (dt != '0) || (d_o != '0);
    end

    // token of the current step, if any
    always_comb begin
        gen_valid = 1'b0;
        gen_word  = i2ew_pkg::W_ZERO;
        case (r_ph)
            i2ew_pkg::P_HDIGIT: begin
                gen_valid = (dh != '0);
                gen_word  = {1'b0, dh};
            end
            i2ew_pkg::P_HWORD: begin
                gen_valid = (dh != '0);
                gen_word  = i2ew_pkg::W_HUNDRED;
            end
            i2ew_pkg::P_TENS: begin
                if (dt == 4'd1) begin
                    gen_valid = 1'b1;
                    gen_word  = i2ew_pkg::W_TEN + {1'b0, d_o};
                end else begin
                    gen_valid = (dt != '0);
                    gen_word  = i2ew_pkg::W_TENS_OFS + {1'b0, dt};
                end
            end
            i2ew_pkg::P_ONES: begin
                gen_valid = (dt != 4'd1) && (d_o != '0);
                gen_word  = {1'b0, d_o};
            end
            i2ew_pkg::P_SCALE: begin
                gen_valid = grp_nz && has_scale;
                gen_word  = scale;
            end
            default: begin
                gen_valid = 1'b0;
                gen_word  = i2ew_pkg::W_ZERO;
            end
        endcase
    end

    assign out_free = !r_out_valid || i_ready;
    assign step_ok  = !gen_valid || !r_pend_valid || out_free;
    assign emit_end = (r_ph == i2ew_pkg::P_SCALE) && (r_grp == 2'd0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2ew_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i2ew_pkg::S_CONV;
                end
            end
            i2ew_pkg::S_CONV: begin
                if (bcd_done) begin
                    n_state = i2ew_pkg::S_EMIT;
                end
            end
            i2ew_pkg::S_EMIT: begin
                if (step_ok && emit_end) begin
                    n_state = i2ew_pkg::S_FLUSH;
                end
            end
            i2ew_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = i2ew_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = i2ew_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        o_ready      = 1'b0;
        start        = 1'b0;
        n_ph         = r_ph;
        n_grp        = r_grp;
        n_pend_valid = r_pend_valid;
        n_pend_word  = r_pend_word;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_word   = r_out_word;
        n_out_last   = r_out_last;
        case (r_state)
            i2ew_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                start        = i_valid;
                n_pend_valid = 1'b0;
                n_ph         = i2ew_pkg::P_HDIGIT;
                n_grp        = 2'd3;
            end
            i2ew_pkg::S_CONV: begin
                n_ph  = i2ew_pkg::P_HDIGIT;
                n_grp = 2'd3;
            end
            i2ew_pkg::S_EMIT: begin
                if (step_ok) begin
                    if (gen_valid) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_word  = r_pend_word;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_word  = gen_word;
                    end
                    case (r_ph)
                        i2ew_pkg::P_HDIGIT: n_ph = i2ew_pkg::P_HWORD;
                        i2ew_pkg::P_HWORD:  n_ph = i2ew_pkg::P_TENS;
                        i2ew_pkg::P_TENS:   n_ph = i2ew_pkg::P_ONES;
                        i2ew_pkg::P_ONES:   n_ph = i2ew_pkg::P_SCALE;
                        default: begin
                            n_ph  = i2ew_pkg::P_HDIGIT;
                            n_grp = r_grp - 2'd1;
                        end
                    endcase
                end
            end
            i2ew_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = r_pend_valid ? r_pend_word : i2ew_pkg::W_ZERO;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= i2ew_pkg::S_IDLE;
            r_ph         <= i2ew_pkg::P_HDIGIT;
            r_grp        <= 2'd3;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ph         <= n_ph;
            r_grp        <= n_grp;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_word <= n_pend_word;
        r_out_word  <= n_out_word;
        r_out_last  <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    assign o_last  = r_out_last;

    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == i2ew_pkg::S_CONV))
        else $error("accepted item did not start conversion");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend_valid)
        else $error("token held while idle");

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcd_done |-> i2ew_pkg::bcd_ok(bcd))
        else $error("conversion gave a non-decimal digit");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2ew_pkg::S_FLUSH && out_free) |=> (o_valid && o_last))
        else $error("final token not marked last");

endmodule
`default_nettype wire
